// ----- design/rdd_pkg.sv -----
// Shared types and constants for the recent-id duplicate filter.
// No dependencies; used by rdd_match, the top level and its checker.
`default_nettype none

package rdd_pkg;

  localparam int unsigned ID_W     = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK_PRESENT = 2'd1;

  typedef struct packed {
    logic [ID_W-1:0] event_id;
    logic            is_active;
    logic            is_audible;
    logic            sink_accepts;
  } in_item_t;

  typedef struct packed {
    logic                sound_request;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/rdd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rdd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/rdd_match.sv -----
// Shared id compare unit: one stored entry against the search key per cycle.
// Depends on rdd_pkg. Id zero never matches; an invalid entry reads as empty.
`default_nettype none

module rdd_match (
  input  wire logic [rdd_pkg::ID_W-1:0] key,
  input  wire logic [rdd_pkg::ID_W-1:0] entry,
  input  wire logic                     entry_valid,
  input  wire logic                     check,
  output logic                          hit
);

  always_comb begin
    hit = check && entry_valid && (key != '0) && (entry == key);
  end

endmodule

`default_nettype wire

// ----- design/recent_id_dedup_filter.sv -----
// Recent-id duplicate filter: top level with sequencer, store and output register.
// Depends on rdd_pkg, rdd_ram and rdd_match.
// The store is scanned one entry per cycle through a single RAM read port, then the
//   result is posted; a new input is taken only once the sequencer is back in idle.
// Reset (rst, synchronous): store empty, insert pointer zero, both config bits one.
`default_nettype none

module recent_id_dedup_filter #(
  parameter int unsigned RECENT_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rdd_pkg::in_item_t             in_data,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rdd_pkg::out_item_t                 out_data,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [rdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rdd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECENT_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration
  logic audio_enable;
  logic sink_present;

  // current transaction
  rdd_pkg::in_item_t item;

  // scan pipeline: issue stage drives the RAM read, check stage compares
  logic             issuing;
  logic [IDX_W-1:0] issue_idx;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             found;

  // store bookkeeping
  logic [RECENT_DEPTH-1:0] entry_valid;
  logic [IDX_W-1:0]        insert_ptr;

  logic [rdd_pkg::ID_W-1:0] rd_data;
  logic                     hit;
  logic                     accept_in;
  logic                     out_free;
  logic                     finish;
  logic                     eligible;
  logic                     do_insert;
  rdd_pkg::out_item_t       result;

  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign finish    = (state == S_DONE) && out_free;
  assign eligible  = item.is_audible && audio_enable && sink_present;

  // Insert only a nonzero id for an eligible, new request the sink takes.
  assign do_insert = finish && item.is_active && eligible && !found &&
                     item.sink_accepts && (item.event_id != '0);

  rdd_ram #(
    .WIDTH (rdd_pkg::ID_W),
    .DEPTH (RECENT_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_insert),
    .wr_addr (insert_ptr),
    .wr_data (item.event_id),
    .rd_en   (issuing),
    .rd_addr (issue_idx),
    .rd_data (rd_data)
  );

  rdd_match u_match (
    .key         (item.event_id),
    .entry       (rd_data),
    .entry_valid (entry_valid[chk_idx]),
    .check       (chk_valid),
    .hit         (hit)
  );

  // Sequencer: idle -> scan every entry -> post result and update the store.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_in) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (chk_valid && (chk_idx == LAST_IDX)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration: only the low bit counts; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_enable <= 1'b1;
      sink_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        rdd_pkg::CFG_AUDIO_ENABLE: audio_enable <= cfg_data[0];
        rdd_pkg::CFG_SINK_PRESENT: sink_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold the accepted transaction for the whole scan.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      item <= in_data;
    end
  end

  // Scan pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      issue_idx <= '0;
      chk_valid <= 1'b0;
      chk_idx   <= '0;
      found     <= 1'b0;
    end else begin
      chk_valid <= issuing;
      chk_idx   <= issue_idx;
      if (accept_in) begin
        issuing   <= 1'b1;
        issue_idx <= '0;
        found     <= 1'b0;
      end else if (issuing) begin
        if (issue_idx == LAST_IDX) begin
          issuing <= 1'b0;
        end else begin
          issue_idx <= issue_idx + 1'b1;
        end
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  // Valid bits: drop an entry that matches a withdrawn id, mark a fresh insert.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      insert_ptr  <= '0;
    end else begin
      if (hit && !item.is_active) begin
        entry_valid[chk_idx] <= 1'b0;
      end
      if (do_insert) begin
        entry_valid[insert_ptr] <= 1'b1;
        insert_ptr <= (insert_ptr == LAST_IDX) ? '0 : insert_ptr + 1'b1;
      end
    end
  end

  // Result decision once every entry has been checked.
  always_comb begin
    result.sound_request = 1'b0;
    result.status        = rdd_pkg::STATUS_OK;
    if (item.is_active && eligible) begin
      if (found) begin
        result.status = rdd_pkg::STATUS_DUPLICATE;
      end else begin
        result.sound_request = 1'b1;
        result.status = item.sink_accepts ? rdd_pkg::STATUS_OK
                                          : rdd_pkg::STATUS_REJECTED;
      end
    end
  end

  // Output register: hold while stalled, load on finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- design/rdd_checker.sv -----
// Port-level checker for the recent-id duplicate filter, bound to the top level.
// Depends on rdd_pkg and recent_id_dedup_filter.
`default_nettype none

module rdd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire rdd_pkg::out_item_t out_data
);

  // A transaction occupies the block: no second one right behind it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on the cycle after a transaction");

  a_dup_no_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sound_request |-> out_data.status != rdd_pkg::STATUS_DUPLICATE)
    else $error("duplicate result carries a sound request");

  a_reject_has_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == rdd_pkg::STATUS_REJECTED |-> out_data.sound_request)
    else $error("rejected status without a sound request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind recent_id_dedup_filter rdd_checker u_rdd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
